### hdl/vmve_pkg.sv
// Shared types and constants for the value-to-MIDI voice encoder.
// Holds the channel payload structs, the register map and the MIDI byte codes.
// No dependencies; every other file imports this package.
package vmve_pkg;

	// One input beat: request type, MIDI channel and fixed-point level.
	typedef struct packed {
		logic [1:0]         req_type;
		logic [3:0]         channel;
		logic signed [31:0] level;
	} item_t;

	// One output beat: a MIDI byte and the end-of-item mark.
	typedef struct packed {
		logic [7:0] midi_byte;
		logic       last_byte;
	} msg_t;

	// Request type codes.
	localparam logic [1:0] REQ_PITCH   = 2'd0;
	localparam logic [1:0] REQ_VOLUME  = 2'd1;
	localparam logic [1:0] REQ_NOTE    = 2'd2;
	localparam logic [1:0] REQ_ALL_OFF = 2'd3;

	// Register map of the configuration port.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_ANCHOR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_ANCHOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_FLOOR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_CEILING  = 3'd4;

	// Register reset values.
	localparam logic [6:0] RST_PITCH_ANCHOR  = 7'd65;
	localparam logic [6:0] RST_VOLUME_ANCHOR = 7'd70;
	localparam logic [6:0] RST_VELOCITY      = 7'd127;
	localparam logic [6:0] RST_NOTE_FLOOR    = 7'd10;
	localparam logic [6:0] RST_NOTE_CEILING  = 7'd100;

	// Current register values as seen by the decoder.
	typedef struct packed {
		logic [6:0] pitch_anchor_note;
		logic [6:0] volume_anchor_note;
		logic [6:0] note_on_velocity;
		logic [6:0] note_floor;
		logic [6:0] note_ceiling;
	} cfg_t;

	// Scale factors applied to the level before the fraction is dropped.
	localparam int FACTOR_W = 9;
	localparam logic [FACTOR_W-1:0] FACTOR_PITCH  = 9'd400;
	localparam logic [FACTOR_W-1:0] FACTOR_VOLUME = 9'd20;
	localparam logic [FACTOR_W-1:0] FACTOR_NOTE   = 9'd5;

	// Clamp limits.
	localparam logic [13:0] PITCH_MAX  = 14'd16383;
	localparam logic [6:0]  VOLUME_MAX = 7'd127;

	// MIDI status nibbles and the volume controller number.
	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_CONTROL  = 4'hB;
	localparam logic [3:0] ST_BEND     = 4'hE;
	localparam logic [7:0] CC_VOLUME   = 8'h07;

	// Kind of byte sequence the serializer plays out.
	typedef enum logic [1:0] {
		PK_OFF_ON,
		PK_BEND,
		PK_VOLUME,
		PK_ALL_OFF
	} plan_kind_t;

	// A decoded item: everything the serializer needs to form its bytes.
	typedef struct packed {
		plan_kind_t  kind;
		logic [3:0]  chan;
		logic [6:0]  note_old;
		logic [6:0]  note_new;
		logic [6:0]  velocity;
		logic [13:0] value;
	} plan_t;

	// Position of the last byte inside a three-byte message.
	localparam logic [1:0] BYTE_LAST = 2'd2;

endpackage

### hdl/vmve_cfg_regs.sv
// Configuration register bank of the value-to-MIDI voice encoder.
// Depends on vmve_pkg for the register map and reset values.
module vmve_cfg_regs
	import vmve_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [6:0]           cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; an index beyond the map is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pitch_anchor_note  <= RST_PITCH_ANCHOR;
			cfg_q.volume_anchor_note <= RST_VOLUME_ANCHOR;
			cfg_q.note_on_velocity   <= RST_VELOCITY;
			cfg_q.note_floor         <= RST_NOTE_FLOOR;
			cfg_q.note_ceiling       <= RST_NOTE_CEILING;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PITCH_ANCHOR: begin
					cfg_q.pitch_anchor_note <= cfg_data;
				end
				CFG_VOLUME_ANCHOR: begin
					cfg_q.volume_anchor_note <= cfg_data;
				end
				CFG_VELOCITY: begin
					cfg_q.note_on_velocity <= cfg_data;
				end
				CFG_NOTE_FLOOR: begin
					cfg_q.note_floor <= cfg_data;
				end
				CFG_NOTE_CEILING: begin
					cfg_q.note_ceiling <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/vmve_decode.sv
// Input register, level scaling, clamping and per-voice state of the encoder.
// Depends on vmve_pkg; hands one plan per byte-producing item to vmve_serializer.
module vmve_decode
	import vmve_pkg::*;
#(
	parameter int NUM_VOICES = 3,
	parameter int FRAC_BITS  = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  item_t                   item,
	input  cfg_t                    cfg,
	output logic                    plan_valid,
	input  logic                    plan_ready,
	output plan_t                   plan,
	output logic [NUM_VOICES*7-1:0] note_flat
);

	localparam int VI_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int PROD_W = 31 + FACTOR_W;

	logic              valid_s1;
	item_t             item_s1;
	logic [6:0]        voice_note_q [NUM_VOICES];
	logic [13:0]       voice_last_q [NUM_VOICES];

	logic              ch_ok;
	logic [VI_W-1:0]   vi;
	logic [FACTOR_W-1:0] factor;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] scaled;
	logic [13:0]       pitch_val;
	logic [6:0]        vol_val;
	logic [6:0]        note_cap;
	logic [6:0]        note_val;
	logic [6:0]        cur_note;
	logic [13:0]       cur_last;
	logic [6:0]        anchor;
	logic [13:0]       val14;
	logic              emit;
	logic              note_we;
	logic [6:0]        note_wval;
	logic              last_we;
	logic              clear_all;
	logic              take_s1;
	logic              plan_fire;

	// Input register: a new beat enters whenever the held one leaves.
	assign take_s1    = valid_s1 && (!emit || plan_ready);
	assign item_stall = valid_s1 && !take_s1;
	assign plan_fire  = valid_s1 && emit && plan_ready;
	assign plan_valid = valid_s1 && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Voice lookup.
	assign ch_ok    = (item_s1.channel != 4'd0) && (5'(item_s1.channel) <= 5'(NUM_VOICES));
	assign vi       = VI_W'(item_s1.channel - 4'd1);
	assign cur_note = voice_note_q[vi];
	assign cur_last = voice_last_q[vi];

	// Scaling: a negative level gives a scaled value of zero.
	always_comb begin
		case (item_s1.req_type)
			REQ_PITCH:  factor = FACTOR_PITCH;
			REQ_VOLUME: factor = FACTOR_VOLUME;
			default:    factor = FACTOR_NOTE;
		endcase
		prod   = PROD_W'(item_s1.level[30:0]) * PROD_W'(factor);
		scaled = item_s1.level[31] ? '0 : (prod >> FRAC_BITS);
	end

	// Clamping per request type; for notes the floor wins over the ceiling.
	always_comb begin
		if (scaled > PROD_W'(PITCH_MAX)) begin
			pitch_val = PITCH_MAX;
		end else if (scaled == '0) begin
			pitch_val = 14'd1;
		end else begin
			pitch_val = scaled[13:0];
		end
		if (scaled > PROD_W'(VOLUME_MAX)) begin
			vol_val = VOLUME_MAX;
		end else if (scaled == '0) begin
			vol_val = 7'd1;
		end else begin
			vol_val = scaled[6:0];
		end
		note_cap = (scaled > PROD_W'(cfg.note_ceiling)) ? cfg.note_ceiling : scaled[6:0];
		note_val = (note_cap < cfg.note_floor) ? cfg.note_floor : note_cap;
	end

	// Decision: which byte sequence this item causes and how the voice changes.
	always_comb begin
		anchor = (item_s1.req_type == REQ_PITCH) ? cfg.pitch_anchor_note
		                                         : cfg.volume_anchor_note;
		val14  = (item_s1.req_type == REQ_PITCH) ? pitch_val : {7'd0, vol_val};

		emit      = 1'b0;
		note_we   = 1'b0;
		note_wval = anchor;
		last_we   = 1'b0;
		clear_all = 1'b0;

		plan.kind     = PK_OFF_ON;
		plan.chan     = item_s1.channel;
		plan.note_old = cur_note;
		plan.note_new = anchor;
		plan.velocity = cfg.note_on_velocity;
		plan.value    = val14;

		if (item_s1.req_type == REQ_ALL_OFF) begin
			emit      = 1'b1;
			clear_all = 1'b1;
			plan.kind = PK_ALL_OFF;
		end else if (ch_ok) begin
			if (item_s1.req_type == REQ_NOTE) begin
				if (cur_note != note_val) begin
					emit          = 1'b1;
					note_we       = 1'b1;
					note_wval     = note_val;
					plan.note_new = note_val;
				end
			end else if (cur_note != anchor) begin
				emit    = 1'b1;
				note_we = 1'b1;
			end else if (cur_last != val14) begin
				emit      = 1'b1;
				last_we   = 1'b1;
				plan.kind = (item_s1.req_type == REQ_PITCH) ? PK_BEND : PK_VOLUME;
			end
		end
	end

	// Voice state, updated when the plan is handed over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				voice_note_q[i] <= 7'd0;
				voice_last_q[i] <= 14'd0;
			end
		end else if (plan_fire) begin
			if (clear_all) begin
				for (int i = 0; i < NUM_VOICES; i++) begin
					voice_note_q[i] <= 7'd0;
				end
			end
			if (note_we) begin
				voice_note_q[vi] <= note_wval;
			end
			if (last_we) begin
				voice_last_q[vi] <= val14;
			end
		end
	end

	// Flat copy of the notes for the all-voices-off sequence.
	always_comb begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			note_flat[i*7 +: 7] = voice_note_q[i];
		end
	end

	// A held item stalls the input only while it waits on the serializer.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && emit && !plan_ready))
		else $error("input stalled without a waiting item");

	// All voices off leaves every voice silent.
	a_all_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(plan_fire && clear_all) |=> (note_flat == '0))
		else $error("voice notes not cleared by all voices off");

	// Voice state changes only when a plan is handed over.
	a_state_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!plan_fire |=> $stable(note_flat))
		else $error("voice note changed without a plan");

endmodule

### hdl/vmve_serializer.sv
// Byte serializer of the value-to-MIDI voice encoder: plays one plan out as
// MIDI bytes through an output register. Depends on vmve_pkg.
module vmve_serializer
	import vmve_pkg::*;
#(
	parameter int NUM_VOICES = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    plan_valid,
	output logic                    plan_ready,
	input  plan_t                   plan,
	input  logic [NUM_VOICES*7-1:0] note_flat,
	output logic                    msg_valid,
	input  logic                    msg_stall,
	output msg_t                    msg
);

	localparam int MSG_N = (NUM_VOICES > 2) ? NUM_VOICES : 2;
	localparam int MSG_W = $clog2(MSG_N);
	localparam logic [MSG_W-1:0] ALL_OFF_LAST = MSG_W'(NUM_VOICES - 1);

	plan_t            plan_s2;
	logic [6:0]       snap_q [NUM_VOICES];
	logic             active_q;
	logic [1:0]       byte_q;
	logic [MSG_W-1:0] msg_q;
	logic             out_valid_q;
	msg_t             out_q;

	logic             advance;
	logic [MSG_W-1:0] msg_last;
	logic             is_last;
	logic             first_msg;
	logic [4:0]       off_ch_wide;
	logic [7:0]       b0;
	logic [7:0]       b1;
	logic [7:0]       b2;
	logic [7:0]       cur_byte;

	// A byte moves into the output register when that register is free or
	// its beat is taken this cycle.
	assign advance    = active_q && (!out_valid_q || !msg_stall);
	assign plan_ready = !active_q || (advance && is_last);
	assign msg_valid  = out_valid_q;
	assign msg        = out_q;

	// Index of the last message of the current plan.
	always_comb begin
		case (plan_s2.kind)
			PK_OFF_ON:  msg_last = MSG_W'(1);
			PK_ALL_OFF: msg_last = ALL_OFF_LAST;
			default:    msg_last = '0;
		endcase
		is_last = (byte_q == BYTE_LAST) && (msg_q == msg_last);
	end

	// Byte formation for the current message and position.
	always_comb begin
		first_msg   = (msg_q == '0);
		off_ch_wide = 5'(msg_q) + 5'd1;
		case (plan_s2.kind)
			PK_OFF_ON: begin
				b0 = {first_msg ? ST_NOTE_OFF : ST_NOTE_ON, plan_s2.chan};
				b1 = {1'b0, first_msg ? plan_s2.note_old : plan_s2.note_new};
				b2 = {1'b0, first_msg ? 7'd0 : plan_s2.velocity};
			end
			PK_BEND: begin
				b0 = {ST_BEND, plan_s2.chan};
				b1 = {1'b0, plan_s2.value[6:0]};
				b2 = {1'b0, plan_s2.value[13:7]};
			end
			PK_VOLUME: begin
				b0 = {ST_CONTROL, plan_s2.chan};
				b1 = CC_VOLUME;
				b2 = {1'b0, plan_s2.value[6:0]};
			end
			default: begin
				b0 = {ST_NOTE_OFF, off_ch_wide[3:0]};
				b1 = {1'b0, snap_q[msg_q]};
				b2 = 8'd0;
			end
		endcase
		case (byte_q)
			2'd0:    cur_byte = b0;
			2'd1:    cur_byte = b1;
			default: cur_byte = b2;
		endcase
	end

	// Sequencer: position counters and the active flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			byte_q   <= 2'd0;
			msg_q    <= '0;
		end else if (plan_valid && plan_ready) begin
			active_q <= 1'b1;
			byte_q   <= 2'd0;
			msg_q    <= '0;
		end else if (advance) begin
			if (is_last) begin
				active_q <= 1'b0;
			end else if (byte_q == BYTE_LAST) begin
				byte_q <= 2'd0;
				msg_q  <= msg_q + MSG_W'(1);
			end else begin
				byte_q <= byte_q + 2'd1;
			end
		end
	end

	// Plan and note snapshot, captured as the plan is taken.
	always_ff @(posedge clk) begin
		if (plan_valid && plan_ready) begin
			plan_s2 <= plan;
			for (int i = 0; i < NUM_VOICES; i++) begin
				snap_q[i] <= note_flat[i*7 +: 7];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!msg_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.midi_byte <= cur_byte;
			out_q.last_byte <= is_last;
		end
	end

	// The byte position never passes the end of a message.
	a_byte_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= BYTE_LAST)
		else $error("byte position out of range");

	// The message index stays within the plan.
	a_msg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (msg_q <= msg_last))
		else $error("message index beyond plan");

	// A plan taken always starts a sequence at its first byte.
	a_plan_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(plan_valid && plan_ready) |=> (active_q && byte_q == 2'd0 && msg_q == '0))
		else $error("plan did not start at its first byte");

endmodule

### hdl/value_to_midi_voice_encoder.sv
// Top level of the value-to-MIDI voice encoder.
// Depends on vmve_pkg, vmve_cfg_regs, vmve_decode and vmve_serializer.
//
//   Port group   Handshake               Beat
//   item         item_valid/item_stall   item_t: req_type, channel, level
//   msg          msg_valid/msg_stall     msg_t: midi_byte, last_byte
//   cfg          cfg_valid/cfg_ready     cfg_index, cfg_data (7 bits)
//
// An item is scaled, clamped and checked against its voice in the input register,
// where it waits until the serializer takes its plan; an item that causes no bytes
// leaves without waiting. Its 3 or 6 bytes (3*NUM_VOICES for all voices off) go out
// one per cycle from the output register while msg_stall is low; the serializer sets
// the rate. Reset clears the voice state and restores the register defaults; there
// is no clearing pass. msg_stall holds the output beat and backs up to item_stall.
module value_to_midi_voice_encoder
	import vmve_pkg::*;
#(
	parameter int NUM_VOICES = 3,
	parameter int FRAC_BITS  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 msg_valid,
	input  logic                 msg_stall,
	output msg_t                 msg,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [6:0]           cfg_data
);

	cfg_t                    cfg;
	logic                    plan_valid;
	logic                    plan_ready;
	plan_t                   plan;
	logic [NUM_VOICES*7-1:0] note_flat;

	// Configuration registers.
	vmve_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register, scaling and voice state.
	vmve_decode #(
		.NUM_VOICES (NUM_VOICES),
		.FRAC_BITS  (FRAC_BITS)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg),
		.plan_valid (plan_valid),
		.plan_ready (plan_ready),
		.plan       (plan),
		.note_flat  (note_flat)
	);

	// Byte serializer and output register.
	vmve_serializer #(
		.NUM_VOICES (NUM_VOICES)
	) u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan_valid (plan_valid),
		.plan_ready (plan_ready),
		.plan       (plan),
		.note_flat  (note_flat),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg        (msg)
	);

endmodule
